// ===== design/positional_list_store_macros.svh =====
// Assertion helpers for the positional list store.
// Each macro takes a label, an antecedent and a consequent; clk and arst_n
// are taken from the module that uses it.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// same-cycle implication
`define PLS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pls: check failed");

// next-cycle implication
`define PLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pls: check failed");

`endif

// ===== design/pls_pkg.sv =====
package pls_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_REM_FRONT = 3'd3,
		OP_REM_BACK  = 3'd4,
		OP_REM_AT    = 3'd5,
		OP_READ_AT   = 3'd6
	} pls_op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} pls_status_t;

	typedef struct packed {
		pls_op_t                  op;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value_in;
	} pls_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		pls_status_t              status;
		logic [CNT_W-1:0]         count_after;
		logic                     is_empty;
	} pls_rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [IDX_W-1:0] at;
	} pls_cell_cmd_t;

	// decode result for the current item
	typedef struct packed {
		pls_status_t      status;
		logic             take;
		logic [CNT_W-1:0] next_count;
	} pls_ctrl_t;

endpackage

// ===== design/pls_cell.sv =====
module pls_cell import pls_pkg::*; (
	input  logic                     clk,
	input  logic [IDX_W-1:0]         idx,
	input  pls_cell_cmd_t            cmd,
	input  logic signed [DATA_W-1:0] value_in,
	input  logic signed [DATA_W-1:0] left_val,
	input  logic signed [DATA_W-1:0] right_val,
	output logic signed [DATA_W-1:0] val,
	output logic signed [DATA_W-1:0] tap
);

	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		if (cmd.ins) begin
			if (idx == cmd.at)
				val_d = value_in;
			else if (idx > cmd.at)
				val_d = left_val;
		end else if (cmd.rem) begin
			if (idx >= cmd.at)
				val_d = right_val;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;
	// masked so the top can OR all taps together
	assign tap = (idx == cmd.at) ? val_q : '0;

endmodule

// ===== design/pls_ctrl.sv =====
module pls_ctrl import pls_pkg::*; (
	input  logic             active,
	input  pls_req_t         req,
	input  logic [CNT_W-1:0] count,
	output pls_cell_cmd_t    cell_cmd,
	output pls_ctrl_t        ctrl
);

	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] at_w;
	logic             is_ins;
	logic             is_rem;
	logic             is_read;

	always_comb begin
		cnt_w   = CMP_W'(count);
		pos_w   = CMP_W'(req.position);
		at_w    = '0;
		is_ins  = 1'b0;
		is_rem  = 1'b0;
		is_read = 1'b0;
		case (req.op)
			OP_INS_FRONT: begin is_ins = 1'b1; at_w = '0; end
			OP_INS_BACK:  begin is_ins = 1'b1; at_w = cnt_w; end
			OP_INS_AT:    begin is_ins = 1'b1; at_w = pos_w; end
			OP_REM_FRONT: begin is_rem = 1'b1; at_w = '0; end
			OP_REM_BACK:  begin is_rem = 1'b1; at_w = cnt_w - CMP_W'(1); end
			OP_REM_AT:    begin is_rem = 1'b1; at_w = pos_w; end
			OP_READ_AT:   begin is_read = 1'b1; at_w = pos_w; end
			default:      begin at_w = '0; end
		endcase

		ctrl.status = ST_OK;
		if (is_ins) begin
			if (at_w > cnt_w)
				ctrl.status = ST_BADPOS;
			else if (cnt_w == CMP_W'(CAPACITY))
				ctrl.status = ST_FULL;
		end else if (is_rem || is_read) begin
			if (cnt_w == '0)
				ctrl.status = ST_EMPTY;
			else if (at_w >= cnt_w)
				ctrl.status = ST_BADPOS;
		end

		ctrl.take       = (is_rem || is_read) && (ctrl.status == ST_OK);
		ctrl.next_count = count;
		if (active && ctrl.status == ST_OK) begin
			if (is_ins)
				ctrl.next_count = count + CNT_W'(1);
			else if (is_rem)
				ctrl.next_count = count - CNT_W'(1);
		end

		// at is below CAPACITY whenever the operation succeeds
		cell_cmd.at  = at_w[IDX_W-1:0];
		cell_cmd.ins = active && is_ins && (ctrl.status == ST_OK);
		cell_cmd.rem = active && is_rem && (ctrl.status == ST_OK);
	end

endmodule

// ===== design/positional_list_store.sv =====
// Channel   | Ports               | Handshake
// ----------+---------------------+-----------------------------------------
// request   | start, busy, req    | taken on a clock edge with start & !busy
// response  | done, rsp           | one-cycle strobe on done, never stalled
//
// For each item, the take edge loads the command register and
// the next edge shifts the cell row and registers the result (done rises too).
// busy covers that execute cycle, so no new item is taken while one executes.
// Reset clears the entry count and the handshake flags; cells are not reset
// and only entries below the count are ever read.
// The receiver cannot stall: done is high for exactly one cycle per item.
`include "positional_list_store_macros.svh"

module positional_list_store import pls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pls_req_t req,
	output logic     done,
	output pls_rsp_t rsp
);

	// command stage
	logic          valid_s1;
	pls_req_t      req_s1;

	// list state
	logic [CNT_W-1:0] count_q;

	// result register
	logic          done_q;
	pls_rsp_t      rsp_q;

	pls_cell_cmd_t            cell_cmd;
	pls_ctrl_t                ctrl;
	logic signed [DATA_W-1:0] cell_val [CAPACITY];
	logic signed [DATA_W-1:0] cell_tap [CAPACITY];
	logic signed [DATA_W-1:0] read_val;

	logic accept;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
			count_q  <= ctrl.next_count;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
		if (valid_s1) begin
			rsp_q.value_out   <= ctrl.take ? read_val : '0;
			rsp_q.status      <= ctrl.status;
			rsp_q.count_after <= ctrl.next_count;
			rsp_q.is_empty    <= (ctrl.next_count == '0);
		end
	end

	pls_ctrl u_ctrl (
		.active   (valid_s1),
		.req      (req_s1),
		.count    (count_q),
		.cell_cmd (cell_cmd),
		.ctrl     (ctrl)
	);

	// row of cells; cell 0 is the front of the list
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_val;
		logic signed [DATA_W-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end
		pls_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.cmd       (cell_cmd),
			.value_in  (req_s1.value_in),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.tap       (cell_tap[i])
		);
	end

	// only the addressed cell drives a nonzero tap
	always_comb begin
		read_val = '0;
		for (int i = 0; i < CAPACITY; i++)
			read_val = read_val | cell_tap[i];
	end

	assign busy = valid_s1;
	assign done = done_q;
	assign rsp  = rsp_q;

	`PLS_ASSERT_NEXT(a_accept_then_busy, accept, busy && !done)
	`PLS_ASSERT_NOW(a_done_not_busy, done, !busy)
	`PLS_ASSERT_NOW(a_empty_flag, done, rsp.is_empty == (rsp.count_after == '0))
	`PLS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`PLS_ASSERT_NEXT(a_count_idle, !valid_s1, count_q == $past(count_q))

endmodule
